// ===== hw/rtl/sce_pkg.sv =====
// Package for the servo command packet encoder: command codes, protocol bytes,
// the packet descriptor passed from the front to the back, and queue sizing.
// No dependencies.
package sce_pkg;

  // Command codes on the operation field
  localparam logic [2:0] OP_STEP_WRITE = 3'd0;
  localparam logic [2:0] OP_SET_ID     = 3'd1;
  localparam logic [2:0] OP_READ       = 3'd2;
  localparam logic [2:0] OP_UNLOCK     = 3'd3;
  localparam logic [2:0] OP_LOCK       = 3'd4;

  // Protocol bytes
  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] LEN_STEP  = 8'h09;
  localparam logic [7:0] LEN_SHORT = 8'h04;
  localparam logic [7:0] INS_WRITE = 8'h03;
  localparam logic [7:0] INS_READ  = 8'h02;
  localparam logic [7:0] REG_STEP  = 8'h2A;
  localparam logic [7:0] REG_ID    = 8'h05;
  localparam logic [7:0] REG_LOCK  = 8'h37;
  localparam logic [7:0] LOCK_OFF  = 8'h00;
  localparam logic [7:0] LOCK_ON   = 8'h01;

  // Byte positions within a packet
  localparam logic [3:0] ID_POS     = 4'd2;
  localparam logic [3:0] LEN_POS    = 4'd3;
  localparam logic [3:0] INS_POS    = 4'd4;
  localparam logic [3:0] BODY_START = 4'd5;

  localparam int BODY_MAX = 7;
  localparam logic [2:0] NBODY_STEP  = 3'd7;
  localparam logic [2:0] NBODY_SHORT = 3'd2;

  // Descriptor queue sizing
  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;
  localparam logic [QAW:0] Q_FULL = (QAW + 1)'(QDEPTH);

  // One packet to be serialised
  typedef struct packed {
    logic [7:0]                 id;
    logic [7:0]                 len;
    logic [7:0]                 instr;
    logic [BODY_MAX-1:0][7:0]   body;
    logic [2:0]                 nbody;
    logic                       run_last;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== hw/rtl/sce_front.sv =====
// Front end: accepts commands and breaks each into packet descriptors.
// Depends on sce_pkg.
module sce_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          operation,
  input  logic [7:0]          servo_id,
  input  logic [15:0]         goal_position,
  input  logic [15:0]         move_time,
  input  logic [15:0]         move_speed,
  input  logic [7:0]          replacement_id,
  input  logic [7:0]          read_register,
  input  logic [7:0]          read_count,
  output logic                push,
  output sce_pkg::pkt_t       pkt,
  input  sce_pkg::qstat_t     qstat
);

  logic        busy;
  logic [1:0]  part;
  logic [2:0]  op_r;
  logic [7:0]  id_r;
  logic [15:0] pos_r;
  logic [15:0] tim_r;
  logic [15:0] spd_r;
  logic [7:0]  new_r;
  logic [7:0]  reg_r;
  logic [7:0]  cnt_r;
  logic        done;
  logic        accept;
  logic        op_ok;

  always_comb begin
    pkt          = '0;
    pkt.id       = id_r;
    pkt.len      = sce_pkg::LEN_SHORT;
    pkt.instr    = sce_pkg::INS_WRITE;
    pkt.nbody    = sce_pkg::NBODY_SHORT;
    pkt.run_last = 1'b1;
    unique case (op_r)
      sce_pkg::OP_STEP_WRITE: begin
        pkt.len     = sce_pkg::LEN_STEP;
        pkt.nbody   = sce_pkg::NBODY_STEP;
        pkt.body[0] = sce_pkg::REG_STEP;
        pkt.body[1] = pos_r[7:0];
        pkt.body[2] = pos_r[15:8];
        pkt.body[3] = tim_r[7:0];
        pkt.body[4] = tim_r[15:8];
        pkt.body[5] = spd_r[7:0];
        pkt.body[6] = spd_r[15:8];
      end
      sce_pkg::OP_SET_ID: begin
        case (part)
          2'd0: begin
            pkt.body[0]  = sce_pkg::REG_LOCK;
            pkt.body[1]  = sce_pkg::LOCK_OFF;
            pkt.run_last = 1'b0;
          end
          2'd1: begin
            pkt.body[0]  = sce_pkg::REG_ID;
            pkt.body[1]  = new_r;
            pkt.run_last = 1'b0;
          end
          default: begin
            pkt.id      = new_r;
            pkt.body[0] = sce_pkg::REG_LOCK;
            pkt.body[1] = sce_pkg::LOCK_ON;
          end
        endcase
      end
      sce_pkg::OP_READ: begin
        pkt.instr   = sce_pkg::INS_READ;
        pkt.body[0] = reg_r;
        pkt.body[1] = cnt_r;
      end
      sce_pkg::OP_UNLOCK: begin
        pkt.body[0] = sce_pkg::REG_LOCK;
        pkt.body[1] = sce_pkg::LOCK_OFF;
      end
      sce_pkg::OP_LOCK: begin
        pkt.body[0] = sce_pkg::REG_LOCK;
        pkt.body[1] = sce_pkg::LOCK_ON;
      end
      default: begin
        pkt.run_last = 1'b1;
      end
    endcase
  end

  // Take the next command in the same cycle as the last descriptor leaves
  assign push     = busy & ~qstat.full;
  assign done     = push & pkt.run_last;
  assign in_stall = busy & ~done;
  assign accept   = in_valid & ~in_stall;
  assign op_ok    = (operation <= sce_pkg::OP_LOCK);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      part <= 2'd0;
    end else if (accept) begin
      busy <= op_ok;
      part <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (push) begin
      part <= part + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= operation;
      id_r  <= servo_id;
      pos_r <= goal_position;
      tim_r <= move_time;
      spd_r <= move_speed;
      new_r <= replacement_id;
      reg_r <= read_register;
      cnt_r <= read_count;
    end
  end

endmodule

// ===== hw/rtl/sce_queue.sv =====
// Short descriptor queue between the front and the back.
// Depends on sce_pkg.
module sce_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sce_pkg::pkt_t     wr_pkt,
  input  logic              pop,
  output sce_pkg::pkt_t     rd_pkt,
  output sce_pkg::qstat_t   qstat
);

  sce_pkg::pkt_t               slots [sce_pkg::QDEPTH];
  logic [sce_pkg::QAW-1:0]     wr_ptr;
  logic [sce_pkg::QAW-1:0]     rd_ptr;
  logic [sce_pkg::QAW:0]       count;

  assign qstat.full  = (count == sce_pkg::Q_FULL);
  assign qstat.empty = (count == '0);
  assign rd_pkt      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_pkt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("descriptor pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("descriptor popped from an empty queue");
`endif

endmodule

// ===== hw/rtl/sce_back.sv =====
// Back end: serialises packet descriptors into bytes with a running checksum.
// Depends on sce_pkg.
module sce_back (
  input  logic              clk,
  input  logic              rst,
  input  sce_pkg::pkt_t     head,
  input  sce_pkg::qstat_t   qstat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              packet_end,
  output logic              run_end
);

  logic           busy;
  sce_pkg::pkt_t  cur;
  logic [3:0]     idx;
  logic [7:0]     sum;
  logic           advance;
  logic           load;
  logic [3:0]     chk_pos;
  logic           is_chk;
  logic [3:0]     body_off;
  logic [7:0]     byte_val;

  assign advance  = busy & (~out_valid | ~out_stall);
  assign chk_pos  = sce_pkg::BODY_START + {1'b0, cur.nbody};
  assign is_chk   = (idx == chk_pos);
  assign body_off = idx - sce_pkg::BODY_START;
  assign load     = (~busy | (advance & is_chk)) & ~qstat.empty;
  assign pop      = load;

  always_comb begin
    if (is_chk) begin
      byte_val = ~sum;
    end else if (idx < sce_pkg::ID_POS) begin
      byte_val = sce_pkg::HDR_BYTE;
    end else if (idx == sce_pkg::ID_POS) begin
      byte_val = cur.id;
    end else if (idx == sce_pkg::LEN_POS) begin
      byte_val = cur.len;
    end else if (idx == sce_pkg::INS_POS) begin
      byte_val = cur.instr;
    end else begin
      byte_val = cur.body[body_off[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (advance & is_chk) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= byte_val;
      packet_end <= is_chk;
      run_end    <= is_chk & cur.run_last;
    end
    if (load) begin
      cur <= head;
      idx <= '0;
      sum <= '0;
    end else if (advance) begin
      idx <= idx + 4'd1;
      if (idx >= sce_pkg::ID_POS) begin
        sum <= sum + byte_val;
      end
    end
  end

`ifndef ASSERT_OFF
  a_run_end_on_checksum: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_end |-> packet_end)
    else $error("run end flagged on a byte that does not end a packet");
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= chk_pos)
    else $error("byte index ran past the checksum");
`endif

endmodule

// ===== hw/rtl/servo_command_packet_encoder.sv =====
// Top level of the servo command packet encoder: front end, descriptor queue
// and byte serialiser. Depends on sce_pkg, sce_front, sce_queue, sce_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------
//   input   | in_valid / in_stall   | operation, servo_id, goal_position,
//           |                       | move_time, move_speed, replacement_id,
//           |                       | read_register, read_count
//   output  | out_valid / out_stall | out_byte, packet_end, run_end
//
// The serialiser emits one byte per cycle while out_stall is low. Byte counts
// per command: 13 for step write, 8 for read, unlock and lock, 24 for set id.
// While the queue has room, the front queues one packet descriptor per cycle
// into the four-entry queue, so a command is taken while earlier packets are
// still being sent. Unknown operation codes are accepted and dropped with no
// output. Reset clears the control state only; nothing else needs clearing.
// A stall on the output holds the registered byte and, once the queue fills,
// backs up into in_stall.
module servo_command_packet_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  servo_id,
  input  logic [15:0] goal_position,
  input  logic [15:0] move_time,
  input  logic [15:0] move_speed,
  input  logic [7:0]  replacement_id,
  input  logic [7:0]  read_register,
  input  logic [7:0]  read_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        packet_end,
  output logic        run_end
);

  // Descriptors travel front -> queue -> back
  logic             push;
  logic             pop;
  sce_pkg::pkt_t    wr_pkt;
  sce_pkg::pkt_t    rd_pkt;
  sce_pkg::qstat_t  qstat;

  // Classify commands and split set id into its three packets
  sce_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .servo_id       (servo_id),
    .goal_position  (goal_position),
    .move_time      (move_time),
    .move_speed     (move_speed),
    .replacement_id (replacement_id),
    .read_register  (read_register),
    .read_count     (read_count),
    .push           (push),
    .pkt            (wr_pkt),
    .qstat          (qstat)
  );

  // Hold descriptors so front and back stall independently
  sce_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_pkt (wr_pkt),
    .pop    (pop),
    .rd_pkt (rd_pkt),
    .qstat  (qstat)
  );

  // Serialise header, fields, body and checksum, one byte per cycle unless stalled
  sce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (rd_pkt),
    .qstat      (qstat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .packet_end (packet_end),
    .run_end    (run_end)
  );

endmodule
